[rtl/bqhp_pkg.sv]
// ----------------------------------------------------------------------------
// bqhp_pkg: shared types and constants
// Word formats, register indexes and the CORDIC angle table for the
// high-pass biquad coefficient generator.
// ----------------------------------------------------------------------------
package bqhp_pkg;

    localparam int CordicSteps = 32;
    localparam int AtanEntries = 40;
    localparam int MaxFrac     = 30;
    localparam logic signed [35:0] CordicGainQ30 = 36'sd652032874;
    localparam logic signed [35:0] OneQ30        = 36'sd1073741824;

    localparam logic [0:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [0:0] CFG_FRAC_BITS   = 1'b1;

    localparam logic [17:0] SampleRateReset = 18'd96000;
    localparam logic [4:0]  FracBitsReset   = 5'd23;

    typedef struct packed {
        logic [16:0] cutoff_hz;
        logic [15:0] q_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         coeff_index;
        logic signed [31:0] coeff_value;
        logic               last;
    } out_word_t;

    // one ratio job handed from the front part to the back part;
    // alpha reaches about 2^37 when Q is at its smallest
    typedef struct packed {
        logic signed [39:0] num;
        logic signed [39:0] den;
        logic [4:0]         fb;
        logic [2:0]         idx;
    } job_t;

    function automatic logic [31:0] atan_turn(input logic [5:0] i);
        logic [31:0] r;
        begin
            case (i)
                6'd0:  r = 32'h20000000;  6'd1:  r = 32'h12E4051E;
                6'd2:  r = 32'h09FB385B;  6'd3:  r = 32'h051111D4;
                6'd4:  r = 32'h028B0D43;  6'd5:  r = 32'h0145D7E1;
                6'd6:  r = 32'h00A2F61E;  6'd7:  r = 32'h00517C55;
                6'd8:  r = 32'h0028BE53;  6'd9:  r = 32'h00145F2F;
                6'd10: r = 32'h000A2F98;  6'd11: r = 32'h000517CC;
                6'd12: r = 32'h00028BE6;  6'd13: r = 32'h000145F3;
                6'd14: r = 32'h0000A2FA;  6'd15: r = 32'h0000517D;
                6'd16: r = 32'h000028BE;  6'd17: r = 32'h0000145F;
                6'd18: r = 32'h00000A30;  6'd19: r = 32'h00000518;
                6'd20: r = 32'h0000028C;  6'd21: r = 32'h00000146;
                6'd22: r = 32'h000000A3;  6'd23: r = 32'h00000051;
                6'd24: r = 32'h00000029;  6'd25: r = 32'h00000014;
                6'd26: r = 32'h0000000A;  6'd27: r = 32'h00000005;
                6'd28: r = 32'h00000003;  6'd29: r = 32'h00000001;
                6'd30: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    typedef enum logic [2:0] {
        FE_IDLE, FE_PHASE, FE_CORDIC, FE_ALPHA, FE_EMIT
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE, BE_INT, BE_FRAC, BE_DONE
    } be_state_t;

endpackage

[rtl/bqhp_front.sv]
// ----------------------------------------------------------------------------
// bqhp_front: request front end
// Forms the phase by restoring division, runs the CORDIC one step a cycle,
// divides for alpha and issues five ratio jobs into the queue.
// ----------------------------------------------------------------------------
module bqhp_front
    import bqhp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  in_word_t      in_word,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [17:0]   sample_rate_hz,
    input  logic [4:0]    frac_bits,
    output job_t          job,
    output logic          job_valid,
    input  logic          job_ready
);

    fe_state_t          state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [48:0]        rem_reg, rem_next;     // dividend bits still to bring down
    logic [17:0]        pr_reg, pr_next;       // partial remainder
    logic [31:0]        quo_reg, quo_next;
    logic signed [35:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [15:0]        q_reg, q_next;
    logic [4:0]         fb_reg, fb_next;
    logic [2:0]         idx_reg, idx_next;
    logic [36:0]        arem_reg, arem_next;
    logic [37:0]        aquo_reg, aquo_next;
    logic               aneg_reg, aneg_next;
    logic signed [36:0] cs_reg, cs_next, sn_reg, sn_next;

    logic signed [35:0] dx, dy;
    logic [19:0]        trial;
    logic [38:0]        atrial;
    logic signed [39:0] alpha, a0, onepc;
    logic [36:0]        snmag;

    assign dx     = y_reg >>> cnt_reg;
    assign dy     = x_reg >>> cnt_reg;
    assign trial  = {1'b0, pr_reg, rem_reg[48]} - {2'b0, sample_rate_hz};
    assign atrial = {1'b0, arem_reg, aquo_reg[37]} - {23'd0, q_reg};
    assign alpha  = aneg_reg ? -$signed({2'b0, aquo_reg}) : $signed({2'b0, aquo_reg});
    assign a0     = 40'(OneQ30) + alpha;
    assign onepc  = 40'(OneQ30) + 40'(cs_reg);
    assign snmag  = sn_reg[36] ? 37'(-sn_reg) : sn_reg;

    // sequence one request
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        pr_next = pr_reg;
        quo_next = quo_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        q_next = q_reg; fb_next = fb_reg; idx_next = idx_reg;
        arem_next = arem_reg; aquo_next = aquo_reg; aneg_next = aneg_reg;
        cs_next = cs_reg; sn_next = sn_reg;
        in_ready = 1'b0;
        job_valid = 1'b0;
        job = '0;
        case (state_reg)
            FE_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rem_next = {in_word.cutoff_hz, 32'd0};
                    pr_next = '0;
                    quo_next = '0;
                    cnt_next = '0;
                    q_next = (in_word.q_value == 16'd0) ? 16'd1 : in_word.q_value;
                    fb_next = (frac_bits > 5'(MaxFrac)) ? 5'(MaxFrac) : frac_bits;
                    state_next = FE_PHASE;
                end
            end
            FE_PHASE:
            begin
                // one quotient bit of cutoff * 2^32 / rate per cycle, keep low 32
                if (!trial[19])
                begin
                    pr_next = trial[17:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    pr_next = {pr_reg[16:0], rem_reg[48]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                rem_next = {rem_reg[47:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd48)
                begin
                    if (sample_rate_hz == 18'd0)
                        quo_next = '0;
                    x_next = CordicGainQ30;
                    y_next = '0;
                    z_next = {4'd0, quo_next[29:0]};
                    cnt_next = '0;
                    state_next = FE_CORDIC;
                end
            end
            FE_CORDIC:
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - dx; y_next = y_reg + dy;
                    z_next = z_reg - $signed({2'b0, atan_turn(cnt_reg)});
                end
                else
                begin
                    x_next = x_reg + dx; y_next = y_reg - dy;
                    z_next = z_reg + $signed({2'b0, atan_turn(cnt_reg)});
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CordicSteps - 1))
                begin
                    case (quo_reg[31:30])
                        2'd0: begin cs_next = 37'(x_next);  sn_next = 37'(y_next);  end
                        2'd1: begin cs_next = -37'(y_next); sn_next = 37'(x_next);  end
                        2'd2: begin cs_next = -37'(x_next); sn_next = -37'(y_next); end
                        default: begin cs_next = 37'(y_next); sn_next = -37'(x_next); end
                    endcase
                    cnt_next = '0;
                    state_next = FE_ALPHA;
                end
            end
            FE_ALPHA:
            begin
                // |sn|*128 / q, restoring, 38 quotient bits
                if (cnt_reg == 6'd0)
                begin
                    aneg_next = sn_reg[36];
                    arem_next = '0;
                    aquo_next = {snmag[30:0], 7'd0};
                end
                else
                begin
                    if (!atrial[38])
                        arem_next = atrial[36:0];
                    else
                        arem_next = {arem_reg[35:0], aquo_reg[37]};
                    if (!atrial[38])
                        aquo_next = {aquo_reg[36:0], 1'b1};
                    else
                        aquo_next = {aquo_reg[36:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd38)
                begin
                    idx_next = '0;
                    state_next = FE_EMIT;
                end
            end
            FE_EMIT:
            begin
                job_valid = 1'b1;
                job.fb = fb_reg;
                job.idx = idx_reg;
                case (idx_reg)
                    3'd0, 3'd2: begin job.num = onepc; job.den = a0 <<< 1; end
                    3'd1:       begin job.num = -onepc; job.den = a0; end
                    3'd3:       begin job.num = 40'(cs_reg) <<< 1; job.den = a0; end
                    default:    begin job.num = alpha - 40'(OneQ30); job.den = a0; end
                endcase
                if (job_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd4)
                        state_next = FE_IDLE;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end

    // hold sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // advance datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next; pr_reg <= pr_next; quo_reg <= quo_next;
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        q_reg <= q_next; fb_reg <= fb_next;
        arem_reg <= arem_next; aquo_reg <= aquo_next; aneg_reg <= aneg_next;
        cs_reg <= cs_next; sn_reg <= sn_next;
    end

endmodule

[rtl/bqhp_fifo.sv]
// ----------------------------------------------------------------------------
// bqhp_fifo: job queue
// Two-entry queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
module bqhp_fifo
    import bqhp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  job_t wr_job,
    input  logic wr_valid,
    output logic wr_ready,
    output job_t rd_job,
    output logic rd_valid,
    input  logic rd_ready
);

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // store word
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_job;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr) wptr_reg <= ~wptr_reg;
            if (do_rd) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

[rtl/bqhp_back.sv]
// ----------------------------------------------------------------------------
// bqhp_back: ratio divider
// Scales num/den by 2^fb with a restoring divider, truncates and saturates,
// and holds the result word in an output register.
// ----------------------------------------------------------------------------
module bqhp_back
    import bqhp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      job,
    input  logic      job_valid,
    output logic      job_ready,
    output out_word_t out_word,
    output logic      out_valid,
    input  logic      out_ready
);

    be_state_t   state_reg, state_next;
    logic [39:0] un_reg, un_next, ud_reg, ud_next;
    logic [40:0] rem_reg, rem_next;
    logic [39:0] ip_reg, ip_next;
    logic [31:0] f_reg, f_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [4:0]  fb_reg, fb_next;
    logic [2:0]  idx_reg, idx_next;
    logic        neg_reg, neg_next;
    logic        nz_reg, nz_next;
    out_word_t   ow_reg, ow_next;
    logic        ov_reg, ov_next;

    logic [41:0] itrial, ftrial;
    logic [62:0] mag;
    logic [31:0] lim;

    assign lim    = 32'h8000_0000;
    assign itrial = {rem_reg, un_reg[39]} - {2'b0, ud_reg};
    assign ftrial = {rem_reg, 1'b0} - {2'b0, ud_reg};
    assign mag    = ({23'd0, ip_reg} << fb_reg) | {31'd0, f_reg};
    assign job_ready = (state_reg == BE_IDLE);
    assign out_word  = ow_reg;
    assign out_valid = ov_reg;

    // divide, one quotient bit a cycle
    always_comb
    begin
        state_next = state_reg;
        un_next = un_reg; ud_next = ud_reg; rem_next = rem_reg;
        ip_next = ip_reg; f_next = f_reg; cnt_next = cnt_reg;
        fb_next = fb_reg; idx_next = idx_reg; neg_next = neg_reg;
        nz_next = nz_reg;
        ow_next = ow_reg;
        ov_next = ov_reg && !out_ready;
        case (state_reg)
            BE_IDLE:
            begin
                if (job_valid)
                begin
                    un_next  = job.num[39] ? 40'(-job.num) : job.num;
                    ud_next  = job.den[39] ? 40'(-job.den) : job.den;
                    neg_next = job.num[39] ^ job.den[39];
                    nz_next  = (job.num == '0);
                    fb_next  = job.fb;
                    idx_next = job.idx;
                    rem_next = '0;
                    ip_next  = '0;
                    f_next   = '0;
                    cnt_next = '0;
                    state_next = BE_INT;
                end
            end
            BE_INT:
            begin
                if (!itrial[41])
                begin
                    rem_next = itrial[40:0];
                    ip_next  = {ip_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[39:0], un_reg[39]};
                    ip_next  = {ip_reg[38:0], 1'b0};
                end
                un_next = {un_reg[38:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd39)
                begin
                    cnt_next = '0;
                    state_next = (fb_reg == 5'd0) ? BE_DONE : BE_FRAC;
                end
            end
            BE_FRAC:
            begin
                if (!ftrial[41])
                begin
                    rem_next = ftrial[40:0];
                    f_next   = {f_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[39:0], 1'b0};
                    f_next   = {f_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(fb_reg - 5'd1))
                    state_next = BE_DONE;
            end
            BE_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    ow_next.coeff_index = idx_reg;
                    ow_next.last = (idx_reg == 3'd4);
                    // drop to zero for a zero numerator, clamp on overflow or a zero divisor
                    if (nz_reg)
                        ow_next.coeff_value = '0;
                    else if (ud_reg == '0 || ip_reg > {8'd0, lim} ||
                             mag >= {31'd0, lim})
                        ow_next.coeff_value = neg_reg ? $signed(lim) : $signed(~lim);
                    else
                        ow_next.coeff_value = neg_reg ? -$signed(mag[31:0])
                                                      : $signed(mag[31:0]);
                    state_next = BE_IDLE;
                end
            end
            default: state_next = BE_IDLE;
        endcase
    end

    // hold control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            ov_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            cnt_reg <= cnt_next;
        end
    end

    // advance datapath
    always_ff @(posedge clk)
    begin
        un_reg <= un_next; ud_reg <= ud_next; rem_reg <= rem_next;
        ip_reg <= ip_next; f_reg <= f_next; fb_reg <= fb_next;
        idx_reg <= idx_next; neg_reg <= neg_next; nz_reg <= nz_next;
        ow_reg <= ow_next;
    end

endmodule

[rtl/biquad_highpass_coefficient_gen.sv]
// ----------------------------------------------------------------------------
// biquad_highpass_coefficient_gen: high-pass biquad coefficient generator
// One request word (cutoff, Q) yields five coefficient words b0, b1, b2,
// -a1, -a2. A request is accepted, then goes through phase division, 32
// CORDIC steps and alpha division in the front end; each coefficient then
// runs through the back-end divider, integer bits first and then frac_bits
// fraction bits (frac_bits capped at 30); it takes a new job only after
// the last result word is in its output register, so output stalls hold
// it. The front end overlaps the next request with the back end's tail.
// ----------------------------------------------------------------------------
module biquad_highpass_coefficient_gen
    import bqhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_word_t    in_data,
    input  logic        in_valid,
    output logic        in_ready,
    output out_word_t   out_data,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    logic [17:0] rate_reg;
    logic [4:0]  fb_reg;
    job_t        fj, bj;
    logic        fj_valid, fj_ready, bj_valid, bj_ready;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= SampleRateReset;
            fb_reg   <= FracBitsReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_RATE: rate_reg <= cfg_data;
                CFG_FRAC_BITS:   fb_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    bqhp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_word(in_data), .in_valid(in_valid), .in_ready(in_ready),
        .sample_rate_hz(rate_reg), .frac_bits(fb_reg),
        .job(fj), .job_valid(fj_valid), .job_ready(fj_ready)
    );

    bqhp_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_job(fj), .wr_valid(fj_valid), .wr_ready(fj_ready),
        .rd_job(bj), .rd_valid(bj_valid), .rd_ready(bj_ready)
    );

    bqhp_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job(bj), .job_valid(bj_valid), .job_ready(bj_ready),
        .out_word(out_data), .out_valid(out_valid), .out_ready(out_ready)
    );

endmodule

[tb/tb_biquad_highpass_coefficient_gen.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_biquad_highpass_coefficient_gen: self-checking bench for the high-pass
// biquad coefficient generator.
// Drives cutoff/Q requests under random handshake gaps, predicts the five
// coefficient words per request and checks every word in order.
// ----------------------------------------------------------------------------
module tb_biquad_highpass_coefficient_gen;
    import bqhp_pkg::*;

    logic        clk;
    logic        rst_n;
    in_word_t    in_data;
    logic        in_valid;
    logic        in_ready;
    out_word_t   out_data;
    logic        out_valid;
    logic        out_ready;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [17:0] cfg_data;

    // shadow copy of the block's registers
    logic [17:0] rate_shadow;
    logic [4:0]  fbits_shadow;

    out_word_t   coeff_queue[$];
    int          fail_count;
    int          words_checked;
    int          requests_sent;
    logic        calm;

    localparam longint unsigned TURN_ATAN [40] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    biquad_highpass_coefficient_gen dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // n/d scaled by 2^fb, truncated toward zero, saturated to int32
    function automatic logic [31:0] fixed_ratio(longint n, longint d, int fb);
        logic neg;
        longint unsigned un, ud, ip, r, f, mag, lim;
        begin
            neg = (n < 0) != (d < 0);
            un  = (n < 0) ? longint'(-n) : n;
            ud  = (d < 0) ? longint'(-d) : d;
            lim = 64'd1 << 31;
            if (un == 0)
                return 32'd0;
            if (ud == 0) begin
                mag = lim;
            end else begin
                ip = un / ud;
                r  = un % ud;
                f  = 0;
                if (ip > lim) begin
                    mag = lim;
                end else begin
                    for (int k = 0; k < fb; k++) begin
                        r = r << 1;
                        f = f << 1;
                        if (r >= ud) begin
                            r = r - ud;
                            f = f | 1;
                        end
                    end
                    mag = (ip << fb) | f;
                end
            end
            if (neg) begin
                if (mag > lim)
                    mag = lim;
                return 32'd0 - mag[31:0];
            end
            if (mag > lim - 1)
                mag = lim - 1;
            return mag[31:0];
        end
    endfunction

    // work out the five coefficient words of one request
    task automatic predict_coeffs(input logic [16:0] cut, input logic [15:0] qv);
        longint unsigned phase64;
        logic [31:0] phase;
        longint q, x, y, z, dx, dy, cs, sn, alpha, a0, onepc;
        longint num[5], den[5];
        int fb;
        out_word_t w;
        begin
            fb = (fbits_shadow > MaxFrac) ? MaxFrac : fbits_shadow;
            phase = 32'd0;
            if (rate_shadow != 0) begin
                phase64 = ({47'd0, cut} << 32) / {46'd0, rate_shadow};
                phase = phase64[31:0];
            end
            q = (qv == 0) ? 1 : qv;
            // rotate from the quadrant base by the low 30 phase bits
            x = 652032874;
            y = 0;
            z = phase[29:0];
            for (int i = 0; i < CordicSteps && i < 40; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - longint'(TURN_ATAN[i]);
                end else begin
                    x = x + dx; y = y - dy; z = z + longint'(TURN_ATAN[i]);
                end
            end
            case (phase[31:30])
                2'd0: begin cs = x;  sn = y;  end
                2'd1: begin cs = -y; sn = x;  end
                2'd2: begin cs = -x; sn = -y; end
                default: begin cs = y; sn = -x; end
            endcase
            alpha = (sn * 128) / q;
            a0    = (longint'(1) <<< 30) + alpha;
            onepc = (longint'(1) <<< 30) + cs;
            num[0] = onepc;  den[0] = 2 * a0;
            num[1] = -onepc; den[1] = a0;
            num[2] = onepc;  den[2] = 2 * a0;
            num[3] = 2 * cs; den[3] = a0;
            num[4] = alpha - (longint'(1) <<< 30); den[4] = a0;
            for (int k = 0; k < 5; k++) begin
                w.coeff_index = k[2:0];
                w.coeff_value = fixed_ratio(num[k], den[k], fb);
                w.last        = (k == 4);
                coeff_queue.push_back(w);
            end
        end
    endtask

    // send one request word, holding valid across back-to-back words
    task automatic send_request(input logic [16:0] cut, input logic [15:0] qv);
        int gap;
        begin
            gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid          <= 1'b1;
            in_data.cutoff_hz <= cut;
            in_data.q_value   <= qv;
            forever
            begin
                @(negedge clk);
                if (in_ready) begin
                    predict_coeffs(cut, qv);
                    requests_sent++;
                    @(posedge clk);
                    break;
                end
                @(posedge clk);
            end
        end
    endtask

    // drop valid and wait until every expected word is in, then let it drain
    task automatic drain;
        begin
            in_valid <= 1'b0;
            while (coeff_queue.size() != 0)
                @(posedge clk);
            repeat (40) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [17:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            cfg_we    <= 1'b0;
            if (idx == CFG_SAMPLE_RATE)
                rate_shadow = val;
            else
                fbits_shadow = val[4:0];
            @(posedge clk);
        end
    endtask

    task automatic set_config(input logic [17:0] rate, input logic [4:0] fb);
        begin
            drain();
            write_reg(CFG_SAMPLE_RATE, rate);
            write_reg(CFG_FRAC_BITS, {13'd0, fb});
        end
    endtask

    // field extremes, Q of zero, cutoff past Nyquist and negative a0
    task automatic test_directed;
        begin
            send_request(17'd1, 16'd0);
            send_request(17'd1, 16'd1);
            send_request(17'd1000, 16'd181);
            send_request(17'd24000, 16'd256);
            send_request(17'd48000, 16'd181);
            send_request(17'd47999, 16'hFFFF);
            send_request(17'd96000, 16'd181);
            send_request(17'h1FFFF, 16'h00FF);
            send_request(17'h15555, 16'hAAAA);
            send_request(17'h0AAAA, 16'h5555);
            send_request(17'd70000, 16'd1);
            send_request(17'd60000, 16'd2);
            send_request(17'd20, 16'd1);
            send_request(17'd5, 16'hFF00);
        end
    endtask

    // random requests, mostly in band with sensible Q, some anywhere
    task automatic test_random(input int count);
        logic [16:0] cut;
        logic [15:0] qv;
        int half;
        begin
            half = (rate_shadow / 2 > 1) ? rate_shadow / 2 : 2;
            if (half > 131071)
                half = 131071;
            for (int n = 0; n < count; n++) begin
                if ($urandom_range(99) < 75) begin
                    cut = 17'($urandom_range(half - 1, 1));
                    qv  = 16'($urandom_range(4096, 32));
                end else begin
                    cut = 17'($urandom);
                    qv  = 16'($urandom);
                end
                send_request(cut, qv);
            end
        end
    endtask

    task automatic test_config_sweep;
        begin
            set_config(18'd8000, 5'd0);
            test_directed();
            test_random(45);
            set_config(18'd192000, 5'd30);
            test_random(45);
            set_config(18'd0, 5'd31);
            send_request(17'd1000, 16'd181);
            test_random(10);
            set_config(18'h3FFFF, 5'd17);
            test_random(45);
            set_config(18'd44100, 5'd1);
            test_random(45);
            set_config(18'd96000, 5'd23);
            test_random(40);
        end
    endtask

    // ready side idles at random unless the bench is in a calm stretch
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 20);
    end

    // compare each accepted word with the oldest expected one
    always @(negedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && out_valid && out_ready) begin
            words_checked++;
            if (coeff_queue.size() == 0) begin
                $error("unexpected coefficient word idx=%0d val=%0d",
                       out_data.coeff_index, out_data.coeff_value);
                fail_count++;
            end else begin
                exp_w = coeff_queue.pop_front();
                if (out_data.coeff_index !== exp_w.coeff_index) begin
                    $error("coeff_index expected %0d actual %0d",
                           exp_w.coeff_index, out_data.coeff_index);
                    fail_count++;
                end
                if (out_data.coeff_value !== exp_w.coeff_value) begin
                    $error("coeff_value expected %0d actual %0d",
                           exp_w.coeff_value, out_data.coeff_value);
                    fail_count++;
                end
                if (out_data.last !== exp_w.last) begin
                    $error("last expected %0b actual %0b", exp_w.last, out_data.last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SAMPLE_RATE;
        cfg_data      = '0;
        rate_shadow   = SampleRateReset;
        fbits_shadow  = FracBitsReset;
        fail_count    = 0;
        words_checked = 0;
        requests_sent = 0;
        calm          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first, with a stretch of no idling on either side
        test_directed();
        calm = 1'b1;
        test_random(50);
        calm = 1'b0;
        test_random(50);
        test_config_sweep();
        drain();

        $display("Covered %0d requests, %0d coefficient words, six register settings",
                 requests_sent, words_checked);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
